>>> rtl/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// Result kinds, control byte codes and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

	// default maximum line length, line store holds one entry less
	localparam int LINE_MAX_DEF = 32;

	// result kinds
	localparam logic [2:0] KIND_ECHO     = 3'd0;
	localparam logic [2:0] KIND_LINE     = 3'd1;
	localparam logic [2:0] KIND_DONE     = 3'd2;
	localparam logic [2:0] KIND_CANCEL   = 3'd3;
	localparam logic [2:0] KIND_EXIT     = 3'd4;
	localparam logic [2:0] KIND_OVERFLOW = 3'd5;

	// console byte codes
	localparam logic [7:0] CH_CTRL_C   = 8'd3;
	localparam logic [7:0] CH_CTRL_D   = 8'd4;
	localparam logic [7:0] CH_BS       = 8'd8;
	localparam logic [7:0] CH_LF       = 8'd10;
	localparam logic [7:0] CH_CR       = 8'd13;
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] CH_CARET    = 8'd94;
	localparam logic [7:0] CH_UPPER_C  = 8'd67;
	localparam logic [7:0] CH_TILDE    = 8'd126;
	localparam logic [7:0] CH_DEL      = 8'd127;

	// source of the tx_byte field of a result word
	typedef enum logic [1:0] {
		TX_ZERO,
		TX_CONST,
		TX_RX,
		TX_STORE
	} tx_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       rx_load;   // latch the accepted input word
		logic       store_wr;  // write rx byte at the cursor
		logic       cur_inc;
		logic       cur_dec;
		logic       cur_clear;
		logic       rd_clear;  // restart the line readout
		logic       rd_issue;  // read the store at the readout index
		logic       rd_inc;
		logic       out_load;  // load the output word register
		logic [2:0] kind;
		tx_sel_t    tx_sel;
		logic [7:0] tx_const;
		logic       use_len;   // line_length carries the cursor
		logic       last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_eol;
		logic is_erase;
		logic is_intr;
		logic is_eof;
		logic is_print;
		logic cursor_zero;
		logic cursor_full;
		logic rd_last;
		logic out_free;
	} status_t;

endpackage

>>> rtl/console_line_editor_core.sv
`timescale 1ns / 1ps
// Flow: an accepted input word is registered and decoded in a decode state; its
// result words then leave through the output register, one result word per cycle
// while the output is not stalled, each line byte by a store read then a load; the
// next input word is taken only once every result word of the last one is loaded.
// Reset: arst_n clears the state machine, cursor and output valid; line store
// contents are not cleared.
// ----------------------------------------------------------------------------
// console_line_editor_core: console line editor top level
// Takes received console bytes, edits a line in a small store and emits echo,
// line and status words through a registered output.
// ----------------------------------------------------------------------------
module console_line_editor_core #(
	parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] tx_byte,
	output logic [4:0] line_length,
	output logic       last
);

	cle_pkg::cmd_t    cmd;
	cle_pkg::status_t sts;

	// sequencer
	cle_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// line store and output word
	cle_datapath #(
		.LINE_MAX (LINE_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.kind        (kind),
		.tx_byte     (tx_byte),
		.line_length (line_length),
		.last        (last)
	);

	// an accepted word blocks the input until its results are issued
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not blocked after accepting a word");

	// a full line never survives to the next input word
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !sts.cursor_full)
		else $error("cursor at line limit while idle");

	// status kinds carry no byte
	a_status_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != cle_pkg::KIND_ECHO && kind != cle_pkg::KIND_LINE
		|-> tx_byte == 8'd0 && last)
		else $error("status word with byte or not last");

	// only line done carries a length
	a_len_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != cle_pkg::KIND_DONE |-> line_length == 5'd0)
		else $error("length on a word other than line done");

endmodule

>>> rtl/cle_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_datapath: line store, cursor and output word register
// Holds the received byte, the line memory with its readout index, the
// cursor and the registered result word; reports byte class and counters.
// ----------------------------------------------------------------------------
module cle_datapath #(
	parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        rx_byte,
	input  cle_pkg::cmd_t     cmd,
	output cle_pkg::status_t  sts,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [2:0]        kind,
	output logic [7:0]        tx_byte,
	output logic [4:0]        line_length,
	output logic              last
);

	localparam int DEPTH = LINE_MAX - 1;
	localparam int CW    = $clog2(LINE_MAX);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]      rx_q;
	logic [CW-1:0]   cursor_q;
	logic [CW-1:0]   rd_q;
	logic [6:0]      rd_data_q;
	logic [6:0]      store_mem [0:DEPTH-1];
	logic            out_valid_q;
	logic [2:0]      kind_q;
	logic [7:0]      tx_q;
	logic [4:0]      len_q;
	logic            last_q;
	logic [CW+4:0]   cursor_ext;
	logic [7:0]      tx_d;

	// received byte
	always_ff @(posedge clk) begin
		if (cmd.rx_load) begin
			rx_q <= rx_byte;
		end
	end

	// cursor and readout index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			rd_q     <= '0;
		end else begin
			if (cmd.cur_clear) begin
				cursor_q <= '0;
			end else if (cmd.cur_dec) begin
				cursor_q <= cursor_q - CW'(1);
			end else if (cmd.cur_inc) begin
				cursor_q <= cursor_q + CW'(1);
			end
			if (cmd.rd_clear) begin
				rd_q <= '0;
			end else if (cmd.rd_inc) begin
				rd_q <= rd_q + CW'(1);
			end
		end
	end

	// byte class, counters and output room
	always_comb begin
		sts.is_eol      = (rx_q == cle_pkg::CH_CR) || (rx_q == cle_pkg::CH_LF);
		sts.is_erase    = (rx_q == cle_pkg::CH_BS) || (rx_q == cle_pkg::CH_DEL);
		sts.is_intr     = (rx_q == cle_pkg::CH_CTRL_C);
		sts.is_eof      = (rx_q == cle_pkg::CH_CTRL_D);
		sts.is_print    = (rx_q >= cle_pkg::CH_SPACE) && (rx_q <= cle_pkg::CH_TILDE);
		sts.cursor_zero = (cursor_q == '0);
		sts.cursor_full = (cursor_q == CW'(DEPTH));
		sts.rd_last     = ((rd_q + CW'(1)) == cursor_q);
		sts.out_free    = !out_valid_q || !out_stall;
	end

	// line memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			store_mem[cursor_q[AW-1:0]] <= rx_q[6:0];
		end
		if (cmd.rd_issue) begin
			rd_data_q <= store_mem[rd_q[AW-1:0]];
		end
	end

	// result word fields
	assign cursor_ext = {5'd0, cursor_q};

	always_comb begin
		case (cmd.tx_sel)
			cle_pkg::TX_CONST: tx_d = cmd.tx_const;
			cle_pkg::TX_RX:    tx_d = rx_q;
			cle_pkg::TX_STORE: tx_d = {1'b0, rd_data_q};
			default:           tx_d = 8'd0;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= cmd.kind;
			tx_q   <= tx_d;
			len_q  <= cmd.use_len ? cursor_ext[4:0] : 5'd0;
			last_q <= cmd.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign tx_byte     = tx_q;
	assign line_length = len_q;
	assign last        = last_q;

endmodule

>>> rtl/cle_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_controller: sequencer of the console line editor
// Accepts one byte, decodes it and steps through the result words it
// causes, one word per state, waiting while a stall holds the output word.
// ----------------------------------------------------------------------------
module cle_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cle_pkg::status_t  sts,
	output cle_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_EOL_NL,
		S_LINE_ADDR,
		S_LINE_EMIT,
		S_DONE,
		S_BS1,
		S_BS2,
		S_BS3,
		S_CC1,
		S_CC2,
		S_CC3,
		S_CC4,
		S_CC5,
		S_EOF1,
		S_EOF2,
		S_PR_ECHO,
		S_PR_OVF
	} state_t;

	state_t state_q;
	state_t state_d;

	// constant echo word
	function automatic cle_pkg::cmd_t echo_const(input logic [7:0] ch, input logic lst);
		cle_pkg::cmd_t c;
		c          = '0;
		c.out_load = 1'b1;
		c.kind     = cle_pkg::KIND_ECHO;
		c.tx_sel   = cle_pkg::TX_CONST;
		c.tx_const = ch;
		c.last     = lst;
		return c;
	endfunction

	// status word with zero tx byte
	function automatic cle_pkg::cmd_t status_word(input logic [2:0] k);
		cle_pkg::cmd_t c;
		c          = '0;
		c.out_load = 1'b1;
		c.kind     = k;
		c.tx_sel   = cle_pkg::TX_ZERO;
		c.last     = 1'b1;
		return c;
	endfunction

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.rx_load = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_eol) begin
					state_d = S_EOL_NL;
				end else if (sts.is_erase) begin
					if (!sts.cursor_zero) begin
						cmd.cur_dec = 1'b1;
						state_d     = S_BS1;
					end else begin
						state_d = S_IDLE;
					end
				end else if (sts.is_intr) begin
					cmd.cur_clear = 1'b1;
					state_d       = S_CC1;
				end else if (sts.is_eof) begin
					state_d = sts.cursor_zero ? S_EOF1 : S_IDLE;
				end else if (sts.is_print) begin
					cmd.store_wr = 1'b1;
					cmd.cur_inc  = 1'b1;
					state_d      = S_PR_ECHO;
				end else begin
					state_d = S_IDLE;
				end
			end
			// end of line: newline, stored bytes, length
			S_EOL_NL: begin
				if (sts.out_free) begin
					cmd          = echo_const(cle_pkg::CH_LF, 1'b0);
					cmd.rd_clear = 1'b1;
					state_d      = sts.cursor_zero ? S_DONE : S_LINE_ADDR;
				end
			end
			S_LINE_ADDR: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_LINE_EMIT;
			end
			S_LINE_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.kind     = cle_pkg::KIND_LINE;
					cmd.tx_sel   = cle_pkg::TX_STORE;
					cmd.rd_inc   = 1'b1;
					state_d      = sts.rd_last ? S_DONE : S_LINE_ADDR;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd           = status_word(cle_pkg::KIND_DONE);
					cmd.use_len   = 1'b1;
					cmd.cur_clear = 1'b1;
					state_d       = S_IDLE;
				end
			end
			// erase: back, space, back
			S_BS1: begin
				if (sts.out_free) begin
					cmd     = echo_const(cle_pkg::CH_BS, 1'b0);
					state_d = S_BS2;
				end
			end
			S_BS2: begin
				if (sts.out_free) begin
					cmd     = echo_const(cle_pkg::CH_SPACE, 1'b0);
					state_d = S_BS3;
				end
			end
			S_BS3: begin
				if (sts.out_free) begin
					cmd     = echo_const(cle_pkg::CH_BS, 1'b1);
					state_d = S_IDLE;
				end
			end
			// interrupt: newline, caret, C, newline, cancel
			S_CC1: begin
				if (sts.out_free) begin
					cmd     = echo_const(cle_pkg::CH_LF, 1'b0);
					state_d = S_CC2;
				end
			end
			S_CC2: begin
				if (sts.out_free) begin
					cmd     = echo_const(cle_pkg::CH_CARET, 1'b0);
					state_d = S_CC3;
				end
			end
			S_CC3: begin
				if (sts.out_free) begin
					cmd     = echo_const(cle_pkg::CH_UPPER_C, 1'b0);
					state_d = S_CC4;
				end
			end
			S_CC4: begin
				if (sts.out_free) begin
					cmd     = echo_const(cle_pkg::CH_LF, 1'b0);
					state_d = S_CC5;
				end
			end
			S_CC5: begin
				if (sts.out_free) begin
					cmd     = status_word(cle_pkg::KIND_CANCEL);
					state_d = S_IDLE;
				end
			end
			// end of input on an empty line
			S_EOF1: begin
				if (sts.out_free) begin
					cmd     = echo_const(cle_pkg::CH_LF, 1'b0);
					state_d = S_EOF2;
				end
			end
			S_EOF2: begin
				if (sts.out_free) begin
					cmd     = status_word(cle_pkg::KIND_EXIT);
					state_d = S_IDLE;
				end
			end
			// printable: echo, then overflow when the line is full
			S_PR_ECHO: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.kind     = cle_pkg::KIND_ECHO;
					cmd.tx_sel   = cle_pkg::TX_RX;
					cmd.last     = !sts.cursor_full;
					state_d      = sts.cursor_full ? S_PR_OVF : S_IDLE;
				end
			end
			S_PR_OVF: begin
				if (sts.out_free) begin
					cmd           = status_word(cle_pkg::KIND_OVERFLOW);
					cmd.cur_clear = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: console line editor core
// Feeds console bytes into the editor, mirrors the line store and cursor to
// work out every echo, line and status word, and checks the output stream in
// order while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LINE_MAX       = cle_pkg::LINE_MAX_DEF;
	localparam int STORE_DEPTH    = LINE_MAX - 1;
	localparam int WORD_GOAL      = 480;
	localparam int MAX_WAIT       = 13;
	localparam int TAIL_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	// one output word of the editor
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] tx_byte;
		logic [4:0] line_length;
		logic       last;
	} out_word_t;

	// directed row: input byte and, where typed, up to two fixed output words
	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		logic [1:0] n_typed;
		out_word_t  w0;
		out_word_t  w1;
	} dir_row_t;

	localparam out_word_t NO_WORD = '0;
	localparam int NDIR = 21;

	localparam dir_row_t DIR_TAB [NDIR] = '{
		// ctrl-d on an empty line asks for exit
		'{cle_pkg::CH_CTRL_D, 1'b1, 2'd2,
			'{cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 5'd0, 1'b0},
			'{cle_pkg::KIND_EXIT, 8'd0, 5'd0, 1'b1}},
		// erase on an empty line is silent
		'{cle_pkg::CH_BS,     1'b1, 2'd0, NO_WORD, NO_WORD},
		'{cle_pkg::CH_DEL,    1'b1, 2'd0, NO_WORD, NO_WORD},
		// ignored extremes of the byte range
		'{8'd0,               1'b1, 2'd0, NO_WORD, NO_WORD},
		'{8'd255,             1'b1, 2'd0, NO_WORD, NO_WORD},
		// end of an empty line
		'{cle_pkg::CH_CR,     1'b1, 2'd2,
			'{cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 5'd0, 1'b0},
			'{cle_pkg::KIND_DONE, 8'd0, 5'd0, 1'b1}},
		// printable extremes
		'{cle_pkg::CH_SPACE,  1'b1, 2'd1,
			'{cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, 5'd0, 1'b1}, NO_WORD},
		'{cle_pkg::CH_TILDE,  1'b1, 2'd1,
			'{cle_pkg::KIND_ECHO, cle_pkg::CH_TILDE, 5'd0, 1'b1}, NO_WORD},
		// control just below printable, ctrl-d on a busy line, tab, high byte
		'{8'd31,              1'b1, 2'd0, NO_WORD, NO_WORD},
		'{cle_pkg::CH_CTRL_D, 1'b1, 2'd0, NO_WORD, NO_WORD},
		'{8'd9,               1'b1, 2'd0, NO_WORD, NO_WORD},
		'{8'd128,             1'b1, 2'd0, NO_WORD, NO_WORD},
		// edits, line readout, cancel
		'{8'd97,              1'b0, 2'd0, NO_WORD, NO_WORD},
		'{cle_pkg::CH_BS,     1'b0, 2'd0, NO_WORD, NO_WORD},
		'{cle_pkg::CH_DEL,    1'b0, 2'd0, NO_WORD, NO_WORD},
		'{cle_pkg::CH_LF,     1'b0, 2'd0, NO_WORD, NO_WORD},
		'{8'd90,              1'b0, 2'd0, NO_WORD, NO_WORD},
		'{cle_pkg::CH_CTRL_C, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{cle_pkg::CH_CR,     1'b0, 2'd0, NO_WORD, NO_WORD},
		'{8'd113,             1'b0, 2'd0, NO_WORD, NO_WORD},
		'{cle_pkg::CH_CR,     1'b0, 2'd0, NO_WORD, NO_WORD}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] tx_byte;
	logic [4:0] line_length;
	logic       last;

	// mirrored editor state
	logic [6:0] line_buf [STORE_DEPTH];
	int         shadow_cursor;

	out_word_t  step_q[$];
	out_word_t  due_q[$];
	out_word_t  due_word;

	int fail_count   = 0;
	int sent_words   = 0;
	int tx_calm      = 0;
	int rx_calm      = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	console_line_editor_core #(
		.LINE_MAX(LINE_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.tx_byte(tx_byte),
		.line_length(line_length),
		.last(last)
	);

	always #1 clk = ~clk;

	// wait per word, with occasional runs of back-to-back words
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(8, 40);
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void push_word(input logic [2:0] k, input logic [7:0] b,
			input logic [4:0] len);
		step_q.push_back('{k, b, len, 1'b0});
	endfunction

	// words the editor emits for one console byte
	task automatic edit_byte(input logic [7:0] b);
		int i;
		step_q.delete();
		if (shadow_cursor >= STORE_DEPTH)
			shadow_cursor = 0;
		if (b == cle_pkg::CH_CR || b == cle_pkg::CH_LF) begin
			push_word(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 5'd0);
			for (i = 0; i < shadow_cursor; i++)
				push_word(cle_pkg::KIND_LINE, {1'b0, line_buf[i]}, 5'd0);
			push_word(cle_pkg::KIND_DONE, 8'd0, 5'(shadow_cursor));
			shadow_cursor = 0;
		end else if (b == cle_pkg::CH_BS || b == cle_pkg::CH_DEL) begin
			if (shadow_cursor > 0) begin
				shadow_cursor--;
				push_word(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 5'd0);
				push_word(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, 5'd0);
				push_word(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 5'd0);
			end
		end else if (b == cle_pkg::CH_CTRL_C) begin
			push_word(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 5'd0);
			push_word(cle_pkg::KIND_ECHO, cle_pkg::CH_CARET, 5'd0);
			push_word(cle_pkg::KIND_ECHO, cle_pkg::CH_UPPER_C, 5'd0);
			push_word(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 5'd0);
			push_word(cle_pkg::KIND_CANCEL, 8'd0, 5'd0);
			shadow_cursor = 0;
		end else if (b == cle_pkg::CH_CTRL_D) begin
			if (shadow_cursor == 0) begin
				push_word(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 5'd0);
				push_word(cle_pkg::KIND_EXIT, 8'd0, 5'd0);
			end
		end else if (b >= cle_pkg::CH_SPACE && b < cle_pkg::CH_DEL) begin
			line_buf[shadow_cursor] = b[6:0];
			shadow_cursor++;
			push_word(cle_pkg::KIND_ECHO, b, 5'd0);
			if (shadow_cursor >= STORE_DEPTH) begin
				push_word(cle_pkg::KIND_OVERFLOW, 8'd0, 5'd0);
				shadow_cursor = 0;
			end
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].last = 1'b1;
	endtask

	// offer one byte, wait for it to be taken, queue its words
	task automatic send_word(input logic [7:0] b, input dir_row_t fixed);
		int gap;
		gap = draw_wait(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		edit_byte(b);
		sent_words++;
		if (fixed.typed) begin
			if (fixed.n_typed > 0)
				due_q.push_back(fixed.w0);
			if (fixed.n_typed > 1)
				due_q.push_back(fixed.w1);
		end else begin
			foreach (step_q[i])
				due_q.push_back(step_q[i]);
		end
	endtask

	// hold the input low until every queued word has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_q.size() != 0)
			@(posedge clk);
	endtask

	// printable text, optionally mixed with erases and stray bytes
	task automatic type_text(input int len, input bit messy);
		int k;
		for (k = 0; k < len; k++) begin
			if (messy && $urandom_range(0, 7) == 0)
				send_word($urandom_range(0, 1) ? cle_pkg::CH_BS : cle_pkg::CH_DEL, '0);
			if (messy && $urandom_range(0, 11) == 0)
				send_word(8'($urandom_range(0, 255)), '0);
			send_word(8'($urandom_range(32, 126)), '0);
		end
	endtask

	// stimulus
	initial begin
		int i;
		int pick;
		int seq_no;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		rx_byte       = 8'd0;
		shadow_cursor = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NDIR; i++)
			send_word(DIR_TAB[i].rx, DIR_TAB[i]);

		seq_no = 0;
		while (sent_words < WORD_GOAL) begin
			if (seq_no == 3 || $urandom_range(0, 14) == 0)
				drain();
			if (seq_no == 0)
				pick = 75;
			else if (seq_no == 1)
				pick = 100;
			else
				pick = $urandom_range(0, 99);

			if (pick < 55) begin
				// ordinary line
				type_text(($urandom_range(0, 5) == 0) ? $urandom_range(9, 30) :
					$urandom_range(0, 8), 1'b1);
				send_word($urandom_range(0, 1) ? cle_pkg::CH_CR : cle_pkg::CH_LF, '0);
			end else if (pick < 70) begin
				// cancelled line
				type_text($urandom_range(0, 6), 1'b1);
				send_word(cle_pkg::CH_CTRL_C, '0);
			end else if (pick < 80) begin
				// fill the store to overflow
				type_text(STORE_DEPTH, 1'b0);
			end else if (pick < 90) begin
				// ctrl-d on an empty or a busy line
				if ($urandom_range(0, 1)) begin
					type_text($urandom_range(1, 4), 1'b0);
					send_word(cle_pkg::CH_CTRL_D, '0);
					send_word(cle_pkg::CH_CR, '0);
				end else begin
					send_word(cle_pkg::CH_CTRL_D, '0);
				end
			end else if (pick < 100) begin
				// stray bytes
				repeat ($urandom_range(1, 6))
					send_word(8'($urandom_range(0, 255)), '0);
			end else begin
				// longest line the store can hold
				type_text(STORE_DEPTH - 1, 1'b0);
				send_word(cle_pkg::CH_CR, '0);
			end
			seq_no++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// output side: random stall, in-order compare
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_q.size() == 0) begin
				$error("word with none expected: kind %0d tx_byte %0d line_length %0d",
					kind, tx_byte, line_length);
				fail_count++;
			end else begin
				due_word = due_q.pop_front();
				if (kind !== due_word.kind) begin
					$error("kind: expected %0d, got %0d", due_word.kind, kind);
					fail_count++;
				end
				if (tx_byte !== due_word.tx_byte) begin
					$error("tx_byte: expected %0d, got %0d", due_word.tx_byte, tx_byte);
					fail_count++;
				end
				if (line_length !== due_word.line_length) begin
					$error("line_length: expected %0d, got %0d",
						due_word.line_length, line_length);
					fail_count++;
				end
				if (last !== due_word.last) begin
					$error("last: expected %0d, got %0d", due_word.last, last);
					fail_count++;
				end
			end
			hold_left = draw_wait(rx_calm);
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= (hold_left > 0);
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

>>> files.f
rtl/cle_pkg.sv
rtl/cle_datapath.sv
rtl/cle_controller.sv
rtl/console_line_editor_core.sv
tb/testbench.sv
